// ===== hw/rtl/mor640_pkg.sv =====
// ----------------------------------------------------------------------------
// mor640_pkg
// Types, constants and round functions shared by the authenticated cipher core
// ----------------------------------------------------------------------------
package mor640_pkg;

  localparam int ROW_W       = 128;
  localparam int WORD_W      = 32;
  localparam int NUM_ROWS    = 5;
  localparam int INIT_ROUNDS = 16;
  localparam int FIN_ROUNDS  = 10;

  localparam int ROT_A = 5;
  localparam int ROT_B = 31;
  localparam int ROT_C = 7;
  localparam int ROT_D = 22;
  localparam int ROT_E = 13;

  localparam logic [ROW_W-1:0] CONST_ROW0 =
    {32'h6279e990, 32'h59372215, 32'h0d080503, 32'h02010100};
  localparam logic [ROW_W-1:0] CONST_ROW1 =
    {32'hdd28b573, 32'h42311120, 32'hf12fc26d, 32'h55183ddb};

  // input mode codes
  localparam logic [2:0] MODE_START = 3'd0;
  localparam logic [2:0] MODE_AD    = 3'd1;
  localparam logic [2:0] MODE_ENC   = 3'd2;
  localparam logic [2:0] MODE_DEC   = 3'd3;
  localparam logic [2:0] MODE_FIN   = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_KEY_LOW    = 2'd0;
  localparam logic [1:0] CFG_KEY_HIGH   = 2'd1;
  localparam logic [1:0] CFG_NONCE_LOW  = 2'd2;
  localparam logic [1:0] CFG_NONCE_HIGH = 2'd3;

  typedef logic [NUM_ROWS-1:0][ROW_W-1:0] state_t;

  typedef enum logic [2:0] {
    OP_START,
    OP_AD,
    OP_ENC,
    OP_DEC,
    OP_FIN,
    OP_NONE
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_KEYX,
    ST_FIN,
    ST_TAG
  } ctrl_state_t;

  typedef struct packed {
    logic accept;
    op_t  op;
    logic upd_zero;
    logic key_xor;
    logic upd_len;
    logic emit_tag;
  } mor_cmd_t;

  function automatic logic [WORD_W-1:0] rotl32(logic [WORD_W-1:0] x, int n);
    return (x << n) | (x >> (WORD_W - n));
  endfunction

  // rotate every word of a row left by n bits
  function automatic logic [ROW_W-1:0] rot_bits(logic [ROW_W-1:0] row, int n);
    logic [ROW_W-1:0] r;
    for (int w = 0; w < 4; w++) begin
      r[WORD_W*w +: WORD_W] = rotl32(row[WORD_W*w +: WORD_W], n);
    end
    return r;
  endfunction

  // word w of the result is word w+k of the row
  function automatic logic [ROW_W-1:0] rot_words(logic [ROW_W-1:0] row, int k);
    logic [ROW_W-1:0] r;
    for (int w = 0; w < 4; w++) begin
      r[WORD_W*w +: WORD_W] = row[WORD_W*((w + k) & 3) +: WORD_W];
    end
    return r;
  endfunction

  function automatic state_t mor_update(state_t s, logic [ROW_W-1:0] m);
    state_t t;
    t    = s;
    t[0] = rot_bits(t[0] ^ t[3] ^ (t[1] & t[2]), ROT_A);
    t[3] = rot_words(t[3], 3);
    t[1] = rot_bits(t[1] ^ m ^ t[4] ^ (t[2] & t[3]), ROT_B);
    t[4] = rot_words(t[4], 2);
    t[2] = rot_bits(t[2] ^ m ^ t[0] ^ (t[3] & t[4]), ROT_C);
    t[0] = rot_words(t[0], 1);
    t[3] = rot_bits(t[3] ^ m ^ t[1] ^ (t[4] & t[0]), ROT_D);
    t[1] = rot_words(t[1], 2);
    t[4] = rot_bits(t[4] ^ m ^ t[2] ^ (t[0] & t[1]), ROT_E);
    t[2] = rot_words(t[2], 3);
    return t;
  endfunction

  function automatic logic [ROW_W-1:0] keystream(state_t s);
    return s[0] ^ rot_words(s[1], 1) ^ (s[2] & s[3]);
  endfunction

  // byte i is kept when i < vb, a count of 16 or more keeps all
  function automatic logic [ROW_W-1:0] byte_mask(logic [4:0] vb);
    logic [ROW_W-1:0] r;
    for (int i = 0; i < 16; i++) begin
      r[8*i +: 8] = (vb > 5'(i)) ? 8'hff : 8'h00;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/mor_in_if.sv =====
// ----------------------------------------------------------------------------
// mor_in_if
// Input channel: one operation with its block and byte counts
// ----------------------------------------------------------------------------
interface mor_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic [4:0]  valid_bytes;
  logic [60:0] ad_byte_count;
  logic [60:0] msg_byte_count;

  modport source (
    output valid, mode, block_low, block_high, valid_bytes, ad_byte_count, msg_byte_count,
    input  ready
  );
  modport sink (
    input  valid, mode, block_low, block_high, valid_bytes, ad_byte_count, msg_byte_count,
    output ready
  );
endinterface

// ===== hw/rtl/mor_out_if.sv =====
// ----------------------------------------------------------------------------
// mor_out_if
// Result channel: output block and tag comparison flag
// ----------------------------------------------------------------------------
interface mor_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_low;
  logic [63:0] out_high;
  logic        tag_match;

  modport source (
    output valid, out_low, out_high, tag_match,
    input  ready
  );
  modport sink (
    input  valid, out_low, out_high, tag_match,
    output ready
  );
endinterface

// ===== hw/rtl/morus640_aead_core.sv =====
// ----------------------------------------------------------------------------
// morus640_aead_core
// Authenticated cipher core with a 640-bit state and a 128-bit key and nonce
// ----------------------------------------------------------------------------
// One transaction on the input channel carries one operation: start, associated
// data, encrypt, decrypt or finalize, and produces exactly one result. Associated
// data, encrypt, decrypt and unused modes finish on acceptance; a new transaction
// is taken when the controller is idle and the output slot is free or draining.
// Start runs load, 16 rounds and key fold, finalize fold, 10 rounds and tag; the
// round counter in the controller counts both. The result of start is returned
// at once while its rounds still run. The user writes key and nonce through the
// cfg port while no transaction is in flight; the core does not enforce this.
module morus640_aead_core
  import mor640_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  mor_in_if.sink      in_ch,
  mor_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  mor_cmd_t cmd;

  mor640_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  mor640_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .cmd            (cmd),
    .block_low      (in_ch.block_low),
    .block_high     (in_ch.block_high),
    .valid_bytes    (in_ch.valid_bytes),
    .ad_byte_count  (in_ch.ad_byte_count),
    .msg_byte_count (in_ch.msg_byte_count),
    .out_low        (out_ch.out_low),
    .out_high       (out_ch.out_high),
    .tag_match      (out_ch.tag_match)
  );

endmodule

// ===== hw/rtl/mor640_datapath.sv =====
// ----------------------------------------------------------------------------
// mor640_datapath
// State rows, key and nonce registers, round function and output register
// ----------------------------------------------------------------------------
module mor640_datapath
  import mor640_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  mor_cmd_t    cmd,
  input  logic [63:0] block_low,
  input  logic [63:0] block_high,
  input  logic [4:0]  valid_bytes,
  input  logic [60:0] ad_byte_count,
  input  logic [60:0] msg_byte_count,
  output logic [63:0] out_low,
  output logic [63:0] out_high,
  output logic        tag_match
);

  logic [63:0]      key_low_r, key_high_r, nonce_low_r, nonce_high_r;
  state_t           state_r, state_nxt;
  logic [ROW_W-1:0] len_r, len_nxt;
  logic [ROW_W-1:0] exp_r, exp_nxt;
  logic [ROW_W-1:0] res_r, res_nxt;
  logic             match_r, match_nxt;

  logic [ROW_W-1:0] key;
  logic [ROW_W-1:0] mask;
  logic [ROW_W-1:0] blk;
  logic [ROW_W-1:0] ks;
  logic [ROW_W-1:0] xres;
  state_t           init_state;

  assign key  = {key_high_r, key_low_r};
  assign mask = byte_mask(valid_bytes);
  assign blk  = {block_high, block_low} & mask;
  assign ks   = keystream(state_r);
  assign xres = (blk ^ ks) & mask;

  always_comb begin
    init_state    = '0;
    init_state[0] = {nonce_high_r, nonce_low_r};
    init_state[1] = key;
    init_state[2] = '1;
    init_state[3] = CONST_ROW0;
    init_state[4] = CONST_ROW1;
  end

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    exp_nxt   = exp_r;
    res_nxt   = res_r;
    match_nxt = match_r;
    if (cmd.accept) begin
      res_nxt   = '0;
      match_nxt = 1'b0;
      unique case (cmd.op)
        OP_START: state_nxt = init_state;
        OP_AD:    state_nxt = mor_update(state_r, blk);
        OP_ENC: begin
          res_nxt   = xres;
          state_nxt = mor_update(state_r, blk);
        end
        OP_DEC: begin
          res_nxt   = xres;
          state_nxt = mor_update(state_r, xres);
        end
        OP_FIN: begin
          state_nxt[4] = state_r[4] ^ state_r[0];
          len_nxt      = {msg_byte_count, 3'b000, ad_byte_count, 3'b000};
          exp_nxt      = {block_high, block_low};
        end
        OP_NONE: ;
        default: ;
      endcase
    end
    if (cmd.upd_zero) begin
      state_nxt = mor_update(state_r, '0);
    end
    if (cmd.key_xor) begin
      state_nxt[1] = state_r[1] ^ key;
    end
    if (cmd.upd_len) begin
      state_nxt = mor_update(state_r, len_r);
    end
    if (cmd.emit_tag) begin
      res_nxt   = ks;
      match_nxt = (ks == exp_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r    <= '0;
      key_high_r   <= '0;
      nonce_low_r  <= '0;
      nonce_high_r <= '0;
      state_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KEY_LOW:    key_low_r    <= cfg_data;
          CFG_KEY_HIGH:   key_high_r   <= cfg_data;
          CFG_NONCE_LOW:  nonce_low_r  <= cfg_data;
          CFG_NONCE_HIGH: nonce_high_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    exp_r   <= exp_nxt;
    res_r   <= res_nxt;
    match_r <= match_nxt;
  end

  assign out_low   = res_r[63:0];
  assign out_high  = res_r[127:64];
  assign tag_match = match_r;

endmodule

// ===== hw/rtl/mor640_ctrl.sv =====
// ----------------------------------------------------------------------------
// mor640_ctrl
// Sequencer for initialization and finalization rounds and the handshakes
// ----------------------------------------------------------------------------
module mor640_ctrl
  import mor640_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_mode,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output mor_cmd_t   cmd
);

  ctrl_state_t state_r, state_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        acc;
  op_t         op;

  always_comb begin
    unique case (in_mode)
      MODE_START: op = OP_START;
      MODE_AD:    op = OP_AD;
      MODE_ENC:   op = OP_ENC;
      MODE_DEC:   op = OP_DEC;
      MODE_FIN:   op = OP_FIN;
      default:    op = OP_NONE;
    endcase
  end

  // a new transaction needs the controller idle and the output slot free or draining this cycle
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign acc      = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (acc && op == OP_START) begin
          state_nxt = ST_INIT;
        end else if (acc && op == OP_FIN) begin
          state_nxt = ST_FIN;
        end
      end
      ST_INIT: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(INIT_ROUNDS - 1)) begin
          state_nxt = ST_KEYX;
        end
      end
      ST_KEYX: state_nxt = ST_IDLE;
      ST_FIN: begin
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'(FIN_ROUNDS - 1)) begin
          state_nxt = ST_TAG;
        end
      end
      ST_TAG:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd          = '0;
    cmd.accept   = acc;
    cmd.op       = op;
    cmd.upd_zero = (state_r == ST_INIT);
    cmd.key_xor  = (state_r == ST_KEYX);
    cmd.upd_len  = (state_r == ST_FIN);
    cmd.emit_tag = (state_r == ST_TAG);

    out_valid_nxt = out_valid_r && !out_ready;
    if ((acc && op != OP_FIN) || state_r == ST_TAG) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
